@@ src/sprite_blit_with_collision_macros.svh @@
// Assertion helpers used by the block's top module.
`ifndef SPRITE_BLIT_WITH_COLLISION_MACROS_SVH
`define SPRITE_BLIT_WITH_COLLISION_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SBC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SBC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/sbc_pkg.sv @@
`default_nettype none

package sbc_pkg;

	localparam logic [7:0] BLANK = 8'h20;
	// Frame addresses stay below 64 rows times 255 columns.
	localparam int ADDR_W = 14;
	localparam int K_W = 10;

	typedef enum logic [2:0] {
		ACT_LOAD  = 3'd0,
		ACT_PLACE = 3'd1,
		ACT_ERASE = 3'd2,
		ACT_CLEAR = 3'd3,
		ACT_READ  = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		REG_FRAME_ROWS  = 2'd0,
		REG_FRAME_COLS  = 2'd1,
		REG_SPRITE_ROWS = 2'd2,
		REG_SPRITE_COLS = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [2:0] action;
		logic [5:0] pos_row;
		logic [6:0] pos_col;
		logic [7:0] sprite_cell_index;
		logic [7:0] cell_value;
	} blit_in_t;

	typedef struct packed {
		logic       placed;
		logic       out_of_bounds;
		logic [7:0] read_char;
	} blit_out_t;

	typedef enum logic [2:0] {
		AU_HOLD,
		AU_LOAD,
		AU_STEP,
		AU_ADV,
		AU_RESTART
	} au_op_t;

	typedef struct packed {
		au_op_t     op;
		logic [5:0] prow;
		logic [6:0] pcol;
	} au_cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [K_W-1:0]    kidx;
		logic              setup_done;
		logic              last;
	} au_status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SETUP,
		ST_RD,
		ST_RD_DATA,
		ST_CHECK,
		ST_CHECK_TAIL,
		ST_WRITE,
		ST_WRITE_TAIL,
		ST_ERASE
	} state_t;

endpackage

`default_nettype wire

@@ src/sprite_blit_with_collision.sv @@
`default_nettype none

// Character frame buffer with one loadable sprite. Requests are taken when start is high and
// busy low; each produces exactly one result, shown for a single cycle with done high, and
// the receiver must take it then. Out of reset the block sweeps the whole frame memory to
// blanks, one cell a cycle, and busy stays high until the sweep is done. A sprite cell load,
// an unused action or an out-of-range request answers in the cycle after the beat. Every frame
// access runs through one frame memory (one write and one read port) and one address adder. A
// read first steps the row base pos_row times, then reads; an erase follows the setup with one
// pass over the R by C sprite cells, a place with a collision check pass and, if no cell is
// hit, a write pass; clear frame sweeps every cell of the frame memory.
module sprite_blit_with_collision #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 128,
	parameter int SPRITE_MAX_ROWS = 16,
	parameter int SPRITE_MAX_COLS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire sbc_pkg::blit_in_t request,
	output logic                   done,
	output sbc_pkg::blit_out_t     result,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [7:0]        cfg_data
);

	import sbc_pkg::*;

	localparam int FDEPTH = MAX_ROWS * MAX_COLS;
	localparam int FAW = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
	localparam int SDEPTH = SPRITE_MAX_ROWS * SPRITE_MAX_COLS;
	localparam int SAW = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;

	logic [6:0] frame_rows_q;
	logic [7:0] frame_cols_q;
	logic [4:0] sprite_rows_q;
	logic [4:0] sprite_cols_q;
	logic [6:0] fr;
	logic [7:0] fc;
	logic [4:0] sr;
	logic [4:0] sc;

	state_t     state_q, state_d;
	blit_in_t   req_q;
	blit_out_t  res_q, res_d;
	logic       done_q, done_d;
	logic       hit_q, hit_now;
	logic       rd_pend_s1;
	logic       wpend_s1;
	logic [FAW-1:0] wa_s1;
	logic [FAW-1:0] clr_q;
	logic       clr_req_q;
	logic       accept;
	logic       oob_region;
	logic       oob_cell;
	logic       sidx_ok;

	au_cmd_t    au_cmd;
	au_status_t au_st;

	logic           f_we;
	logic [FAW-1:0] f_waddr;
	logic [7:0]     f_wdata;
	logic [FAW-1:0] f_raddr;
	logic [7:0]     f_rdata;
	logic           s_we;
	logic [7:0]     s_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q  <= 7'd64;
			frame_cols_q  <= 8'd128;
			sprite_rows_q <= 5'd1;
			sprite_cols_q <= 5'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_ROWS:  frame_rows_q  <= cfg_data[6:0];
				REG_FRAME_COLS:  frame_cols_q  <= cfg_data;
				REG_SPRITE_ROWS: sprite_rows_q <= cfg_data[4:0];
				REG_SPRITE_COLS: sprite_cols_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Saturate the dimensions to the range the stores can hold.
	always_comb begin
		if (frame_rows_q == 7'd0) begin
			fr = 7'd1;
		end else if (32'(frame_rows_q) > MAX_ROWS) begin
			fr = 7'(MAX_ROWS);
		end else begin
			fr = frame_rows_q;
		end
		if (frame_cols_q == 8'd0) begin
			fc = 8'd1;
		end else if (32'(frame_cols_q) > MAX_COLS) begin
			fc = 8'(MAX_COLS);
		end else begin
			fc = frame_cols_q;
		end
		if (sprite_rows_q == 5'd0) begin
			sr = 5'd1;
		end else if (32'(sprite_rows_q) > SPRITE_MAX_ROWS) begin
			sr = 5'(SPRITE_MAX_ROWS);
		end else begin
			sr = sprite_rows_q;
		end
		if (sprite_cols_q == 5'd0) begin
			sc = 5'd1;
		end else if (32'(sprite_cols_q) > SPRITE_MAX_COLS) begin
			sc = 5'(SPRITE_MAX_COLS);
		end else begin
			sc = sprite_cols_q;
		end
	end

	assign accept     = start && (state_q == ST_IDLE);
	assign busy       = (state_q != ST_IDLE);
	assign oob_region = (({1'b0, request.pos_row} + {2'b00, sr}) > fr) ||
	                    (({1'b0, request.pos_col} + {3'b000, sc}) > fc);
	assign oob_cell   = ({1'b0, request.pos_row} >= fr) || ({1'b0, request.pos_col} >= fc);
	assign sidx_ok    = (32'(request.sprite_cell_index) < SDEPTH);
	assign hit_now    = hit_q || (rd_pend_s1 && (f_rdata != BLANK));

	always_comb begin
		state_d     = state_q;
		au_cmd.op   = AU_HOLD;
		au_cmd.prow = request.pos_row;
		au_cmd.pcol = request.pos_col;
		f_we        = 1'b0;
		f_waddr     = FAW'(au_st.addr);
		f_wdata     = BLANK;
		f_raddr     = FAW'(au_st.addr);
		s_we        = 1'b0;
		done_d      = 1'b0;
		res_d       = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (request.action)
						ACT_LOAD: begin
							s_we   = sidx_ok;
							done_d = 1'b1;
						end
						ACT_PLACE, ACT_ERASE: begin
							if (oob_region) begin
								done_d              = 1'b1;
								res_d.out_of_bounds = 1'b1;
							end else begin
								au_cmd.op = AU_LOAD;
								state_d   = ST_SETUP;
							end
						end
						ACT_CLEAR: begin
							state_d = ST_CLEAR;
						end
						ACT_READ: begin
							if (oob_cell) begin
								done_d              = 1'b1;
								res_d.out_of_bounds = 1'b1;
							end else begin
								au_cmd.op = AU_LOAD;
								state_d   = ST_SETUP;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			ST_SETUP: begin
				// Build row * stride by repeated addition, then branch on the request.
				if (!au_st.setup_done) begin
					au_cmd.op = AU_STEP;
				end else begin
					case (req_q.action)
						ACT_READ:  state_d = ST_RD;
						ACT_PLACE: state_d = ST_CHECK;
						ACT_ERASE: state_d = ST_ERASE;
						default: begin
							state_d = ST_IDLE;
							done_d  = 1'b1;
						end
					endcase
				end
			end
			ST_RD: begin
				state_d = ST_RD_DATA;
			end
			ST_RD_DATA: begin
				done_d          = 1'b1;
				res_d.read_char = f_rdata;
				state_d         = ST_IDLE;
			end
			ST_CHECK: begin
				au_cmd.op = AU_ADV;
				if (au_st.last) begin
					state_d = ST_CHECK_TAIL;
				end
			end
			ST_CHECK_TAIL: begin
				if (hit_now) begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					au_cmd.op = AU_RESTART;
					state_d   = ST_WRITE;
				end
			end
			ST_WRITE: begin
				au_cmd.op = AU_ADV;
				f_we      = wpend_s1;
				f_waddr   = wa_s1;
				f_wdata   = s_rdata;
				if (au_st.last) begin
					state_d = ST_WRITE_TAIL;
				end
			end
			ST_WRITE_TAIL: begin
				f_we         = wpend_s1;
				f_waddr      = wa_s1;
				f_wdata      = s_rdata;
				done_d       = 1'b1;
				res_d.placed = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_ERASE: begin
				au_cmd.op = AU_ADV;
				f_we      = 1'b1;
				if (au_st.last) begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_CLEAR: begin
				f_we    = 1'b1;
				f_waddr = clr_q;
				if (clr_q == FAW'(FDEPTH - 1)) begin
					done_d  = clr_req_q;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			done_q     <= 1'b0;
			clr_q      <= '0;
			clr_req_q  <= 1'b0;
			hit_q      <= 1'b0;
			rd_pend_s1 <= 1'b0;
			wpend_s1   <= 1'b0;
		end else begin
			state_q    <= state_d;
			done_q     <= done_d;
			rd_pend_s1 <= (state_q == ST_CHECK);
			wpend_s1   <= (state_q == ST_WRITE);
			if (accept) begin
				hit_q <= 1'b0;
				clr_q <= '0;
				if (request.action == ACT_CLEAR) begin
					clr_req_q <= 1'b1;
				end
			end else if (state_q == ST_CHECK) begin
				hit_q <= hit_now;
			end else if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + FAW'(1);
				if (clr_q == FAW'(FDEPTH - 1)) begin
					clr_req_q <= 1'b0;
				end
			end
		end
	end

	// Hold the beat, the result and the pending write address; no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
		if (done_d) begin
			res_q <= res_d;
		end
		wa_s1 <= FAW'(au_st.addr);
	end

	sbc_addr_unit u_addr (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (au_cmd),
		.fc     (fc),
		.sr     (sr),
		.sc     (sc),
		.status (au_st)
	);

	sbc_ram #(
		.DEPTH (FDEPTH),
		.AW    (FAW),
		.W     (8)
	) u_frame (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	sbc_ram #(
		.DEPTH (SDEPTH),
		.AW    (SAW),
		.W     (8)
	) u_sprite (
		.clk   (clk),
		.we    (s_we),
		.waddr (SAW'(request.sprite_cell_index)),
		.wdata (request.cell_value),
		.raddr (SAW'(au_st.kidx)),
		.rdata (s_rdata)
	);

	assign done   = done_q;
	assign result = res_q;

`include "sprite_blit_with_collision_macros.svh"

	`SBC_ASSERT_IMP(a_done_when_idle, done, !busy, "result shown while busy")
	`SBC_ASSERT_IMP(a_flags_exclusive, done, !(result.placed && result.out_of_bounds),
		"placed and out_of_bounds together")
	`SBC_ASSERT_NXT(a_accept_progress, accept, done || busy, "beat dropped after accept")
	`SBC_ASSERT_IMP(a_frame_write_range, f_we, 32'(f_waddr) < FDEPTH,
		"frame write beyond store")

endmodule

`default_nettype wire

@@ src/sbc_ram.sv @@
`default_nettype none

module sbc_ram #(
	parameter int DEPTH = 256,
	parameter int AW = 8,
	parameter int W = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem_q [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ src/sbc_addr_unit.sv @@
`default_nettype none

module sbc_addr_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sbc_pkg::au_cmd_t    cmd,
	input  wire logic [7:0]          fc,
	input  wire logic [4:0]          sr,
	input  wire logic [4:0]          sc,
	output sbc_pkg::au_status_t      status
);

	import sbc_pkg::*;

	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] start_q;
	logic [ADDR_W-1:0] sum;
	logic [7:0]        skip_q;
	logic [7:0]        step;
	logic [5:0]        mcnt_q;
	logic [4:0]        ri_q;
	logic [4:0]        ci_q;
	logic [K_W-1:0]    k_q;
	logic              col_end;

	assign col_end = (ci_q == sc - 5'd1);

	// One adder: row stride while forming the base, then column or row skip.
	always_comb begin
		if (cmd.op == AU_STEP) begin
			step = fc;
		end else if (col_end) begin
			step = skip_q;
		end else begin
			step = 8'd1;
		end
		sum = addr_q + {{(ADDR_W-8){1'b0}}, step};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q <= '0;
			ri_q   <= '0;
			ci_q   <= '0;
			k_q    <= '0;
		end else begin
			case (cmd.op)
				AU_LOAD: begin
					mcnt_q <= cmd.prow;
					ri_q   <= '0;
					ci_q   <= '0;
					k_q    <= '0;
				end
				AU_STEP: begin
					mcnt_q <= mcnt_q - 6'd1;
				end
				AU_ADV: begin
					k_q <= k_q + K_W'(1);
					if (col_end) begin
						ci_q <= '0;
						ri_q <= ri_q + 5'd1;
					end else begin
						ci_q <= ci_q + 5'd1;
					end
				end
				AU_RESTART: begin
					ri_q <= '0;
					ci_q <= '0;
					k_q  <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			AU_LOAD: begin
				addr_q  <= {{(ADDR_W-7){1'b0}}, cmd.pcol};
				start_q <= {{(ADDR_W-7){1'b0}}, cmd.pcol};
				skip_q  <= fc - {3'b000, sc} + 8'd1;
			end
			AU_STEP: begin
				addr_q  <= sum;
				start_q <= sum;
			end
			AU_ADV: begin
				addr_q <= sum;
			end
			AU_RESTART: begin
				addr_q <= start_q;
			end
			default: ;
		endcase
	end

	assign status.addr       = addr_q;
	assign status.kidx       = k_q;
	assign status.setup_done = (mcnt_q == 6'd0);
	assign status.last       = col_end && (ri_q == sr - 5'd1);

endmodule

`default_nettype wire
